// ----- sv/rrtq_pkg.sv -----
// rrtq_pkg: shared types and constants for the round-robin task queue manager.
// No dependencies.
package rrtq_pkg;

    localparam int MAX_TASKS = 16;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_YIELD  = 3'd1,
        CMD_BLOCK  = 3'd2,
        CMD_EXIT   = 3'd3,
        CMD_KILL   = 3'd4,
        CMD_REAP   = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] target_id;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] task_id;
        logic [3:0] prev_id;
        logic       switched;
        logic       valid_res;
        logic       last;
    } res_t;

endpackage

// ----- sv/round_robin_task_queue_manager.sv -----
// round_robin_task_queue_manager: top level, front request path and back engine.
// Depends on rrtq_pkg, rrtq_queue, rrtq_engine.
//
// Usage: drive req (command, target_id) and raise start; the request is taken
// at a rising edge with start high and busy low. Results appear on res for
// exactly one cycle each, marked by done; res.last flags the final one of a
// request. The receiver cannot stall, so results are never held back.
// Sequencing: create and unknown commands are answered straight from idle; yield
// and block go through the scheduler; exit and kill walk the ready then the wait
// list, one link a cycle (a kill of the current task also schedules).
// Reap gives its zombies one result a cycle.
// The front queue holds requests while the engine walks a list; busy rises
// when it is full. One request at a time is worked on by the engine.
// Reset: task 0 running as the idle task, all other slots exited, lists
// empty, next id 1. Link storage is not cleared; it is written before read.
module round_robin_task_queue_manager (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rrtq_pkg::req_t  req,
    output logic            busy,
    output logic            done,
    output rrtq_pkg::res_t  res
);
    logic            q_full, q_ne, q_pop;
    rrtq_pkg::req_t  q_head;
    logic            eng_idle;

    assign busy = q_full;

    // front: request queue decoupling acceptance from execution
    rrtq_queue #(.DEPTH(2)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(start), .push_data(req), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    // back: table, lists and sequencer
    rrtq_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_ne), .req(q_head), .req_pop(q_pop),
        .idle(eng_idle), .res_strobe(done), .res(res)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> eng_idle)
        else $error("pop while engine busy");
    assert property (@(posedge clk) disable iff (!rst_n) (done && !res.last) |=> done)
        else $error("result burst broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.status == rrtq_pkg::STS_FULL) |-> !res.valid_res)
        else $error("full status with valid id");
endmodule

// ----- sv/rrtq_queue.sv -----
// rrtq_queue: small request FIFO between the front and back parts.
// Depends on rrtq_pkg.
module rrtq_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rrtq_pkg::req_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rrtq_pkg::req_t  head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rrtq_pkg::req_t   mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> not_empty)
        else $error("full but empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push lost");
endmodule

// ----- sv/rrtq_engine.sv -----
// rrtq_engine: back part; task state table, linked lists and command sequencer.
// Depends on rrtq_pkg.
module rrtq_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  rrtq_pkg::req_t  req,
    output logic            req_pop,
    output logic            idle,
    output logic            res_strobe,
    output rrtq_pkg::res_t  res
);
    localparam int MAX_TASKS = rrtq_pkg::MAX_TASKS;
    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ID_LIMIT = (MAX_TASKS < 16) ? MAX_TASKS : 16;
    localparam logic [4:0] NUL = 5'd31;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_SCHED, S_FIND, S_RWALK, S_WWALK, S_KDONE, S_REAP
    } state_t;

    state_t         state_reg;
    logic [1:0]     ts_reg [MAX_TASKS];
    logic [4:0]     lnk_reg [MAX_TASKS];
    logic [4:0]     rh_reg, rt_reg, wh_reg, wt_reg, zh_reg, zt_reg;
    logic [3:0]     run_reg;
    logic [4:0]     idc_reg;
    logic [3:0]     tgt_reg;
    logic [4:0]     cur_reg, prv_reg;
    logic [6:0]     n_reg;
    logic           found_reg;
    logic           kexit_reg;
    rrtq_pkg::res_t res_reg;
    logic           stb_reg;

    assign res        = res_reg;
    assign res_strobe = stb_reg;
    assign idle       = (state_reg == S_IDLE);
    assign req_pop    = idle && req_valid;

    function automatic logic ok(input logic [4:0] v);
        ok = ({2'b0, v} < 7'(MAX_TASKS));
    endfunction

    function automatic rrtq_pkg::res_t mk(input logic [1:0] s, input logic [3:0] t,
        input logic [3:0] p, input logic sw, input logic v, input logic l);
        rrtq_pkg::res_t r;
        r.status = s; r.task_id = t; r.prev_id = p;
        r.switched = sw; r.valid_res = v; r.last = l;
        mk = r;
    endfunction

    logic [4:0] rd_link;
    assign rd_link = lnk_reg[cur_reg[SW-1:0]];

    logic       exit_walk;
    assign exit_walk = (req.command == rrtq_pkg::CMD_EXIT) && ok({1'b0, run_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [4:0] h, t, nx, prev5, nxt;
        logic [1:0] st;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                ts_reg[i] <= (i == 0) ? rrtq_pkg::ST_RUNNING : rrtq_pkg::ST_EXITED;
            end
            rh_reg <= NUL; rt_reg <= NUL; wh_reg <= NUL; wt_reg <= NUL;
            zh_reg <= NUL; zt_reg <= NUL;
            run_reg <= '0;
            idc_reg <= 5'd1;
            stb_reg <= 1'b0;
            tgt_reg <= '0; cur_reg <= NUL; prv_reg <= NUL;
            n_reg <= '0; found_reg <= 1'b0; kexit_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            stb_reg <= 1'b0;
            case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    tgt_reg <= exit_walk ? run_reg : req.target_id;
                    kexit_reg <= exit_walk;
                    case (req.command)
                    rrtq_pkg::CMD_CREATE:
                    begin
                        stb_reg <= 1'b1;
                        if (idc_reg >= 5'(ID_LIMIT))
                        begin
                            res_reg <= mk(rrtq_pkg::STS_FULL, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            idc_reg <= idc_reg + 5'd1;
                            ts_reg[idc_reg[SW-1:0]] <= rrtq_pkg::ST_READY;
                            lnk_reg[idc_reg[SW-1:0]] <= NUL;
                            if (rh_reg == NUL || !ok(rt_reg))
                                rh_reg <= idc_reg;
                            else
                                lnk_reg[rt_reg[SW-1:0]] <= idc_reg;
                            rt_reg <= idc_reg;
                            res_reg <= mk(rrtq_pkg::STS_OK, idc_reg[3:0], 4'd0, 1'b0, 1'b1,
                                          1'b1);
                        end
                    end
                    rrtq_pkg::CMD_YIELD: state_reg <= S_SCHED;
                    rrtq_pkg::CMD_BLOCK, rrtq_pkg::CMD_EXIT:
                    begin
                        if (ok({1'b0, run_reg}))
                        begin
                            ts_reg[run_reg[SW-1:0]] <= (req.command == rrtq_pkg::CMD_BLOCK)
                                ? rrtq_pkg::ST_BLOCKED : rrtq_pkg::ST_EXITED;
                        end
                        if (exit_walk)
                        begin
                            cur_reg <= rh_reg; prv_reg <= NUL; n_reg <= '0;
                            state_reg <= S_RWALK;
                        end
                        else
                            state_reg <= S_SCHED;
                    end
                    rrtq_pkg::CMD_KILL:
                    begin
                        found_reg <= 1'b0;
                        cur_reg <= rh_reg; prv_reg <= NUL; n_reg <= '0;
                        state_reg <= S_RWALK;
                    end
                    rrtq_pkg::CMD_REAP:
                    begin
                        if (!ok(zh_reg))
                        begin
                            stb_reg <= 1'b1;
                            res_reg <= mk(rrtq_pkg::STS_OK, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            n_reg <= '0;
                            state_reg <= S_REAP;
                        end
                    end
                    default:
                    begin
                        stb_reg <= 1'b1;
                        res_reg <= mk(rrtq_pkg::STS_OK, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1);
                    end
                    endcase
                end
            end
            // walk the ready list removing tgt; then the wait list
            S_RWALK, S_WWALK:
            begin
                if (n_reg < 7'(MAX_TASKS) && ok(cur_reg) && cur_reg != {1'b0, tgt_reg})
                begin
                    prv_reg <= cur_reg;
                    cur_reg <= rd_link;
                    n_reg <= n_reg + 7'd1;
                end
                else
                begin
                    if (n_reg < 7'(MAX_TASKS) && ok(cur_reg))
                    begin
                        found_reg <= 1'b1;
                        if (state_reg == S_RWALK)
                        begin
                            if (prv_reg == NUL) rh_reg <= rd_link;
                            else lnk_reg[prv_reg[SW-1:0]] <= rd_link;
                            if (rt_reg == cur_reg) rt_reg <= prv_reg;
                        end
                        else
                        begin
                            if (prv_reg == NUL) wh_reg <= rd_link;
                            else lnk_reg[prv_reg[SW-1:0]] <= rd_link;
                            if (wt_reg == cur_reg) wt_reg <= prv_reg;
                        end
                    end
                    if (state_reg == S_RWALK)
                    begin
                        cur_reg <= wh_reg; prv_reg <= NUL; n_reg <= '0;
                        state_reg <= S_WWALK;
                    end
                    else
                        state_reg <= kexit_reg ? S_SCHED : S_KDONE;
                end
            end
            S_KDONE:
            begin
                if (!found_reg || !ok({1'b0, tgt_reg}))
                begin
                    stb_reg <= 1'b1;
                    res_reg <= mk(rrtq_pkg::STS_NOT_FOUND, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1);
                    state_reg <= S_IDLE;
                end
                else
                begin
                    ts_reg[tgt_reg[SW-1:0]] <= rrtq_pkg::ST_EXITED;
                    if (tgt_reg == run_reg)
                        state_reg <= S_SCHED;
                    else
                    begin
                        lnk_reg[tgt_reg[SW-1:0]] <= NUL;
                        if (zh_reg == NUL || !ok(zt_reg)) zh_reg <= {1'b0, tgt_reg};
                        else lnk_reg[zt_reg[SW-1:0]] <= {1'b0, tgt_reg};
                        zt_reg <= {1'b0, tgt_reg};
                        stb_reg <= 1'b1;
                        res_reg <= mk(rrtq_pkg::STS_OK, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
            end
            S_SCHED:
            begin
                stb_reg <= 1'b1;
                state_reg <= S_IDLE;
                if (!ok(rh_reg) || rh_reg == {1'b0, run_reg})
                begin
                    res_reg <= mk(rrtq_pkg::STS_OK, run_reg, run_reg, 1'b0, 1'b1, 1'b1);
                end
                else
                begin
                    // pop head, then file outgoing task; head link read first
                    h = rh_reg; t = rt_reg;
                    nx = lnk_reg[rh_reg[SW-1:0]];
                    st = ok({1'b0, run_reg}) ? ts_reg[run_reg[SW-1:0]] : rrtq_pkg::ST_READY;
                    nxt = nx;
                    if (st == rrtq_pkg::ST_RUNNING && ok({1'b0, run_reg}))
                    begin
                        // append run to ready, then pop head
                        ts_reg[run_reg[SW-1:0]] <= rrtq_pkg::ST_READY;
                        lnk_reg[run_reg[SW-1:0]] <= NUL;
                        if (!ok(t)) nxt = {1'b0, run_reg};
                        else if (t == h) nxt = {1'b0, run_reg};
                        else lnk_reg[t[SW-1:0]] <= {1'b0, run_reg};
                        rh_reg <= nxt;
                        rt_reg <= {1'b0, run_reg};
                    end
                    else
                    begin
                        rh_reg <= nx;
                        if (nx == NUL) rt_reg <= NUL;
                        if (ok({1'b0, run_reg}) && st == rrtq_pkg::ST_BLOCKED)
                        begin
                            lnk_reg[run_reg[SW-1:0]] <= NUL;
                            if (wh_reg == NUL || !ok(wt_reg)) wh_reg <= {1'b0, run_reg};
                            else lnk_reg[wt_reg[SW-1:0]] <= {1'b0, run_reg};
                            wt_reg <= {1'b0, run_reg};
                        end
                        if (ok({1'b0, run_reg}) && st == rrtq_pkg::ST_EXITED)
                        begin
                            lnk_reg[run_reg[SW-1:0]] <= NUL;
                            if (zh_reg == NUL || !ok(zt_reg)) zh_reg <= {1'b0, run_reg};
                            else lnk_reg[zt_reg[SW-1:0]] <= {1'b0, run_reg};
                            zt_reg <= {1'b0, run_reg};
                        end
                    end
                    prev5 = {1'b0, run_reg};
                    ts_reg[h[SW-1:0]] <= rrtq_pkg::ST_RUNNING;
                    run_reg <= h[3:0];
                    res_reg <= mk(rrtq_pkg::STS_OK, h[3:0], prev5[3:0], 1'b1, 1'b1, 1'b1);
                end
            end
            S_REAP:
            begin
                zh_reg <= lnk_reg[zh_reg[SW-1:0]];
                if (lnk_reg[zh_reg[SW-1:0]] == NUL) zt_reg <= NUL;
                n_reg <= n_reg + 7'd1;
                stb_reg <= 1'b1;
                if (n_reg + 7'd1 >= 7'(ID_LIMIT) || !ok(lnk_reg[zh_reg[SW-1:0]]))
                begin
                    res_reg <= mk(rrtq_pkg::STS_OK, zh_reg[3:0], 4'd0, 1'b0, 1'b1, 1'b1);
                    state_reg <= S_IDLE;
                end
                else
                    res_reg <= mk(rrtq_pkg::STS_OK, zh_reg[3:0], 4'd0, 1'b0, 1'b1, 1'b0);
            end
            default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (stb_reg && res_reg.last) |-> state_reg == S_IDLE)
        else $error("last result while still working");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rh_reg == NUL) == (rt_reg == NUL))
        else $error("ready list ends disagree");
    assert property (@(posedge clk) disable iff (!rst_n)
        (zh_reg == NUL) == (zt_reg == NUL))
        else $error("zombie list ends disagree");
    assert property (@(posedge clk) disable iff (!rst_n)
        (stb_reg && res_reg.switched) |-> res_reg.task_id != res_reg.prev_id)
        else $error("switch to same task");
endmodule
